FILE: design/pcf_pkg.sv
// Package for the PNG chunk framer: job descriptor, queue sizing, CRC-32 step,
// signature table and byte select helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

  // Job queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Input mode codes
  localparam logic [1:0] MODE_SIG   = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;

  // Byte index limits inside one job
  localparam logic [3:0] IDX_SIG_END      = 4'd7;
  localparam logic [3:0] IDX_HDR_END      = 4'd7;
  localparam logic [3:0] IDX_HDR_CRC_END  = 4'd11;
  localparam logic [3:0] IDX_DATA_END     = 4'd0;
  localparam logic [3:0] IDX_DATA_CRC_END = 4'd4;

  // Header byte groups, selected by idx[3:2]
  localparam logic [1:0] GRP_LEN  = 2'd0;
  localparam logic [1:0] GRP_TYPE = 2'd1;

  typedef enum logic [1:0] {
    JOB_SIG,
    JOB_HDR,
    JOB_DATA,
    JOB_MISUSE
  } job_kind_e;

  // One classified request, as handed from front to back
  typedef struct packed {
    job_kind_e   kind;
    logic        close;   // CRC trailer follows
    logic [30:0] length;
    logic [31:0] ctype;
    logic [7:0]  data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Fold one byte into the running CRC
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = CRC_POLY ^ (c >> 1);
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // PNG file signature
  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
    endcase
    return b;
  endfunction

  // Big-endian byte select: 0 gives bits 31..24
  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      2'd3: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/pcf_front.sv
// Front of the PNG chunk framer: accepts requests, tracks the open chunk and
// its remaining payload count, and pushes classified jobs. Uses pcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcf_front import pcf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [30:0] chunk_length_i,
  input  wire logic [31:0] chunk_type_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire q_status_t   q_status_i,
  output logic             push_o,
  output job_t             job_o
);

  logic        chunk_open_q, chunk_open_d;
  logic [30:0] bytes_left_q, bytes_left_d;
  logic [30:0] left_m1;
  logic        accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign left_m1    = bytes_left_q - 31'd1;

  // Classify the request and update chunk bookkeeping
  always_comb begin
    chunk_open_d = chunk_open_q;
    bytes_left_d = bytes_left_q;
    push_o       = 1'b0;
    job_o.kind   = JOB_SIG;
    job_o.close  = 1'b0;
    job_o.length = chunk_length_i;
    job_o.ctype  = chunk_type_i;
    job_o.data   = data_byte_i;
    if (accept) begin
      unique case (mode_i)
        MODE_SIG: begin
          push_o     = 1'b1;
          job_o.kind = JOB_SIG;
        end
        MODE_BEGIN: begin
          push_o       = 1'b1;
          job_o.kind   = JOB_HDR;
          job_o.close  = (chunk_length_i == 31'd0);
          chunk_open_d = (chunk_length_i != 31'd0);
          bytes_left_d = chunk_length_i;
        end
        MODE_DATA: begin
          push_o = 1'b1;
          if (!chunk_open_q) begin
            job_o.kind = JOB_MISUSE;
          end else begin
            job_o.kind   = JOB_DATA;
            job_o.close  = (left_m1 == 31'd0);
            chunk_open_d = (left_m1 != 31'd0);
            bytes_left_d = left_m1;
          end
        end
        default: begin
          // unused mode: dropped
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_open_q <= 1'b0;
      bytes_left_q <= 31'd0;
    end else begin
      chunk_open_q <= chunk_open_d;
      bytes_left_q <= bytes_left_d;
    end
  end

`ifndef SYNTH
  // A chunk is open exactly while payload bytes remain
  a_open_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_open_q == (bytes_left_q != 31'd0))
    else $error("chunk_open out of step with bytes_left");
`endif

endmodule

`default_nettype wire

FILE: design/pcf_queue.sv
// Short job queue between front and back of the PNG chunk framer.
// Register-based FIFO of job_t, depth QDEPTH. Uses pcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcf_queue import pcf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  job_t           mem_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;
  logic           do_push, do_pop;

  assign status_o.full  = (count_q == QCW'(QDEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Storage, cleared at reset so the head never reads as unknown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '{default: '0};
    end else if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCW'(1);
      end
    end
  end

`ifndef SYNTH
  // Fill count stays within depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QDEPTH))
    else $error("job queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: design/pcf_back.sv
// Back of the PNG chunk framer: serializes queued jobs into output bytes,
// keeps the running CRC-32 and appends the trailer. Uses pcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcf_back import pcf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire job_t      head_i,
  input  wire q_status_t q_status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           chunk_done_o,
  output logic           misuse_o,
  output logic           last_o
);

  logic [3:0]  idx_q, idx_d;
  logic [31:0] crc_q, crc_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        chunk_done_q, misuse_q, last_q;

  logic        out_free, advance;
  logic [7:0]  nb_byte;
  logic        nb_done, nb_misuse, nb_end, crc_upd;
  logic [31:0] crc_base;
  logic [31:0] crc_out;
  logic [1:0]  crc_sel;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = !q_status_i.empty && out_free;
  assign pop_o    = advance && nb_end;
  assign crc_out  = ~crc_q;
  // trailer after a data byte: index 1..4 picks CRC byte 0..3
  assign crc_sel  = idx_q[1:0] - 2'd1;

  // Next byte of the head job
  always_comb begin
    nb_byte   = 8'd0;
    nb_done   = 1'b0;
    nb_misuse = 1'b0;
    nb_end    = 1'b0;
    crc_upd   = 1'b0;
    crc_base  = crc_q;
    unique case (head_i.kind)
      JOB_SIG: begin
        nb_byte = sig_byte(idx_q[2:0]);
        nb_end  = (idx_q == IDX_SIG_END);
      end
      JOB_HDR: begin
        if (idx_q[3:2] == GRP_LEN) begin
          nb_byte = byte_of({1'b0, head_i.length}, idx_q[1:0]);
        end else if (idx_q[3:2] == GRP_TYPE) begin
          nb_byte = byte_of(head_i.ctype, idx_q[1:0]);
          crc_upd = 1'b1;
          // first type byte restarts the CRC
          if (idx_q[1:0] == 2'd0) begin
            crc_base = CRC_INIT;
          end
        end else begin
          nb_byte = byte_of(crc_out, idx_q[1:0]);
          nb_done = (idx_q == IDX_HDR_CRC_END);
        end
        nb_end = head_i.close ? (idx_q == IDX_HDR_CRC_END) : (idx_q == IDX_HDR_END);
      end
      JOB_DATA: begin
        if (idx_q == IDX_DATA_END) begin
          nb_byte = head_i.data;
          crc_upd = 1'b1;
        end else begin
          nb_byte = byte_of(crc_out, crc_sel);
          nb_done = (idx_q == IDX_DATA_CRC_END);
        end
        nb_end = head_i.close ? (idx_q == IDX_DATA_CRC_END) : (idx_q == IDX_DATA_END);
      end
      JOB_MISUSE: begin
        nb_byte   = 8'd0;
        nb_misuse = 1'b1;
        nb_end    = 1'b1;
      end
    endcase
  end

  // Byte counter and CRC state
  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (advance) begin
      idx_d = nb_end ? 4'd0 : idx_q + 4'd1;
      if (crc_upd) begin
        crc_d = crc_byte(crc_base, nb_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
      if (out_free) begin
        out_valid_q <= !q_status_i.empty;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q   <= nb_byte;
      chunk_done_q <= nb_done;
      misuse_q     <= nb_misuse;
      last_q       <= nb_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign chunk_done_o = chunk_done_q;
  assign misuse_o     = misuse_q;
  assign last_o       = last_q;

`ifndef SYNTH
  // Byte index never runs past a closing header
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_HDR_CRC_END)
    else $error("byte index out of range");

  // The final CRC byte always ends its request
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && chunk_done_q |-> last_q)
    else $error("chunk_done without last");

  // A misuse result is a lone zero byte
  a_misuse_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && misuse_q |-> last_q && !chunk_done_q && out_byte_q == 8'd0)
    else $error("malformed misuse result");
`endif

endmodule

`default_nettype wire

FILE: design/png_chunk_framer_crc32_top.sv
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_stall_o  mode_i, chunk_length_i, chunk_type_i, data_byte_i
// out      out  out_valid_o/out_stall_i out_byte_o, chunk_done_o, misuse_o, last_o
//
// One output byte per cycle while a job is queued and out_stall_i is low; an input
// request produces 1 byte per payload byte, 5 when it closes the chunk, 8 or 12 for a
// header, 8 for the signature. The output serializer in the back emits these bytes.
// A two-entry job queue lets requests be taken while the back still emits.
// Reset is asynchronous, active low; no clearing pass. Either side may stall.
// Top level of the PNG chunk framer; uses pcf_pkg, pcf_front, pcf_queue, pcf_back.
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_framer_crc32_top import pcf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [30:0] chunk_length_i,
  input  wire logic [31:0] chunk_type_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             chunk_done_o,
  output logic             misuse_o,
  output logic             last_o
);

  q_status_t q_status;
  job_t      push_job, head_job;
  logic      push, pop;

  pcf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .chunk_length_i (chunk_length_i),
    .chunk_type_i   (chunk_type_i),
    .data_byte_i    (data_byte_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .job_o          (push_job)
  );

  pcf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .head_o   (head_job),
    .status_o (q_status)
  );

  pcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .chunk_done_o (chunk_done_o),
    .misuse_o     (misuse_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for png_chunk_framer_crc32_top: directed and random
// requests, per-byte compare against an internal framer/CRC-32 predictor.
// Depends on pcf_pkg (mode codes, CRC constants) and the framer RTL.
`timescale 1ns / 1ps

module testbench import pcf_pkg::*; ();

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTED  = 40;

  localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

  // One request on the input channel
  typedef struct {
    logic [1:0]  mode;
    logic [30:0] length;
    logic [31:0] ctype;
    logic [7:0]  data;
  } framer_req_t;

  // One byte of the framed stream
  typedef struct {
    logic [7:0] value;
    logic       done;
    logic       misuse;
    logic       last;
  } stream_byte_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [1:0]  mode_i         = MODE_SIG;
  logic [30:0] chunk_length_i = '0;
  logic [31:0] chunk_type_i   = '0;
  logic [7:0]  data_byte_i    = '0;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        chunk_done_o;
  logic        misuse_o;
  logic        last_o;

  png_chunk_framer_crc32_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .chunk_length_i (chunk_length_i),
    .chunk_type_i   (chunk_type_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .chunk_done_o   (chunk_done_o),
    .misuse_o       (misuse_o),
    .last_o         (last_o)
  );

  always #10 clk_i = ~clk_i;

  framer_req_t  pending_reqs[$];
  stream_byte_t expected_stream[$];

  // Predictor state
  logic [31:0] crc_acc       = CRC_INIT;
  logic [30:0] payload_left  = '0;
  logic        chunk_is_open = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_on       = 1'b0;
  event        hold_kick;

  int unsigned mismatch_count = 0;
  int unsigned reqs_sent      = 0;
  int unsigned bytes_checked  = 0;
  int unsigned chunks_closed  = 0;
  int unsigned misuse_seen    = 0;
  int unsigned in_stall_seen  = 0;
  int unsigned cycle_count    = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s got 0x%02h want 0x%02h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Reflected CRC-32, one data bit at a time
  function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = (c >> 1) ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic void append_byte(input logic [7:0] v, input logic done,
                                      input logic mis);
    stream_byte_t s;
    s.value  = v;
    s.done   = done;
    s.misuse = mis;
    s.last   = 1'b0;
    expected_stream.push_back(s);
  endfunction

  // Trailer: complemented CRC, big-endian, closes the chunk
  function automatic void append_crc();
    logic [31:0] v;
    v = crc_acc ^ CRC_INIT;
    for (int i = 3; i >= 0; i--) begin
      append_byte(v[8*i +: 8], i == 0, 1'b0);
    end
    chunk_is_open = 1'b0;
    payload_left  = '0;
  endfunction

  // Expected bytes for one request; updates the predictor state
  function automatic void frame_request(input framer_req_t r);
    int unsigned n0;
    logic [31:0] len32;
    n0    = expected_stream.size();
    len32 = {1'b0, r.length};
    case (r.mode)
      MODE_SIG: begin
        for (int i = 0; i < 8; i++) begin
          append_byte(PNG_MAGIC[i], 1'b0, 1'b0);
        end
      end
      MODE_BEGIN: begin
        for (int i = 3; i >= 0; i--) begin
          append_byte(len32[8*i +: 8], 1'b0, 1'b0);
        end
        crc_acc = CRC_INIT;
        for (int i = 3; i >= 0; i--) begin
          append_byte(r.ctype[8*i +: 8], 1'b0, 1'b0);
          crc_acc = crc32_fold(crc_acc, r.ctype[8*i +: 8]);
        end
        payload_left  = r.length;
        chunk_is_open = 1'b1;
        if (r.length == '0) begin
          append_crc();
        end
      end
      MODE_DATA: begin
        if (!chunk_is_open) begin
          append_byte(8'h00, 1'b0, 1'b1);
        end else begin
          append_byte(r.data, 1'b0, 1'b0);
          crc_acc      = crc32_fold(crc_acc, r.data);
          payload_left = payload_left - 31'd1;
          if (payload_left == '0) begin
            append_crc();
          end
        end
      end
      default: ;
    endcase
    if (expected_stream.size() > n0) begin
      expected_stream[expected_stream.size() - 1].last = 1'b1;
    end
  endfunction

  // Input driver; every request put on the bus is accepted in order, so it is
  // predicted as it is issued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin : drive_req
      framer_req_t r;
      if (in_valid_i && in_stall_o) begin
        in_stall_seen++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          frame_request(r);
          reqs_sent++;
          in_valid_i     <= 1'b1;
          mode_i         <= r.mode;
          chunk_length_i <= r.length;
          chunk_type_i   <= r.ctype;
          data_byte_i    <= r.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output stall, random or held off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // Long receiver hold-off
  always begin
    @(hold_kick);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Output monitor
  always @(posedge clk_i) begin : check_out
    stream_byte_t s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stream.size() == 0) begin
        report_mismatch("byte with nothing expected", out_byte_o, 8'h00);
      end else begin
        s = expected_stream.pop_front();
        bytes_checked++;
        if (out_byte_o !== s.value) begin
          report_mismatch("out_byte", out_byte_o, s.value);
        end
        if (chunk_done_o !== s.done) begin
          report_mismatch("chunk_done", {7'd0, chunk_done_o}, {7'd0, s.done});
        end
        if (misuse_o !== s.misuse) begin
          report_mismatch("misuse", {7'd0, misuse_o}, {7'd0, s.misuse});
        end
        if (last_o !== s.last) begin
          report_mismatch("last", {7'd0, last_o}, {7'd0, s.last});
        end
        if (s.done) begin
          chunks_closed++;
        end
        if (s.misuse) begin
          misuse_seen++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic void queue_request(input logic [1:0] mode, input logic [30:0] len,
                                        input logic [31:0] ctype, input logic [7:0] data);
    framer_req_t r;
    r.mode   = mode;
    r.length = len;
    r.ctype  = ctype;
    r.data   = data;
    pending_reqs.push_back(r);
  endfunction

  function automatic framer_req_t random_request(input logic [1:0] mode);
    framer_req_t r;
    r.mode   = mode;
    r.length = 31'($urandom());
    r.ctype  = $urandom();
    r.data   = 8'($urandom());
    return r;
  endfunction

  // Mostly well-formed chunks with random content; some broken off, some
  // signatures, some with huge lengths, and some plain noise
  function automatic void add_random(input int unsigned target);
    int unsigned added;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    framer_req_t r;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        cut = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
        r = random_request(MODE_BEGIN);
        r.length = 31'(len);
        pending_reqs.push_back(r);
        added++;
        for (int unsigned i = 0; i < cut; i++) begin
          pending_reqs.push_back(random_request(MODE_DATA));
          added++;
        end
      end else if (pick < 75) begin
        pending_reqs.push_back(random_request(MODE_SIG));
        added++;
      end else if (pick < 85) begin
        pending_reqs.push_back(random_request(MODE_BEGIN));
        added++;
        cut = $urandom_range(4);
        for (int unsigned i = 0; i < cut; i++) begin
          pending_reqs.push_back(random_request(MODE_DATA));
          added++;
        end
      end else begin
        r = random_request(2'($urandom_range(3)));
        pending_reqs.push_back(r);
        if (r.mode != MODE_UNUSED) begin
          added++;
        end
      end
    end
  endfunction

  task automatic drain_pending();
    while (pending_reqs.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: signature, zero-length chunks, misuse, ignored mode,
    // begin and signature while open, length extremes
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_request(MODE_SIG, '0, '0, '0);
    queue_request(MODE_BEGIN, '0, 32'hFFFF_FFFF, '0);
    queue_request(MODE_BEGIN, '0, 32'h0000_0000, '0);
    queue_request(MODE_DATA, '0, '0, 8'hFF);
    queue_request(MODE_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    queue_request(MODE_BEGIN, 31'd3, 32'h4948_4452, '0);
    queue_request(MODE_DATA, '0, '0, 8'h00);
    queue_request(MODE_SIG, '0, '0, '0);
    queue_request(MODE_UNUSED, '0, '0, 8'h00);
    queue_request(MODE_DATA, '0, '0, 8'hFF);
    queue_request(MODE_DATA, '0, '0, 8'h5A);
    queue_request(MODE_DATA, '0, '0, 8'h00);
    queue_request(MODE_BEGIN, 31'h7FFF_FFFF, 32'h4944_4154, '0);
    queue_request(MODE_DATA, '0, '0, 8'hA5);
    queue_request(MODE_BEGIN, 31'd1, 32'h4945_4E44, '0);
    queue_request(MODE_DATA, '0, '0, 8'h80);
    queue_request(MODE_BEGIN, 31'd2, 32'hFFFF_FFFF, '0);
    queue_request(MODE_DATA, '0, '0, 8'h01);
    queue_request(MODE_DATA, '0, '0, 8'hFE);
    queue_request(MODE_BEGIN, '0, 32'h4945_4E44, '0);
    add_random(75);
    drain_pending();

    // Sparse sender
    send_idle_pct = 88;
    add_random(75);
    drain_pending();

    // Slow receiver
    send_idle_pct = 0;
    stall_pct     = 88;
    add_random(75);
    drain_pending();

    // Receiver held off while the sender keeps pushing
    stall_pct = 0;
    -> hold_kick;
    add_random(30);
    drain_pending();

    // Both sides idle now and then
    send_idle_pct = 30;
    stall_pct     = 30;
    add_random(50);
    drain_pending();

    while (in_valid_i || expected_stream.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("requests sent %0d, stream bytes checked %0d, chunks closed %0d",
             reqs_sent, bytes_checked, chunks_closed);
    $display("misuse bytes %0d, input stall cycles %0d, mismatches %0d",
             misuse_seen, in_stall_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
